// ===== rtl/pcs_pkg.sv =====
package pcs_pkg;

	// fixed field widths
	localparam int COORD_W = 16;
	localparam int OUT_W   = 24;

	// edge arithmetic widths
	localparam int SUM2_W  = COORD_W + 1;          // px + x
	localparam int CROSS_W = 2 * COORD_W + 1;      // px*y - x*py
	localparam int PROD_W  = SUM2_W + CROSS_W;     // shared multiplier output
	localparam int AREA_W  = CROSS_W + 15;         // room for the edges of a MAX_VERTICES_DEF ring
	localparam int WSUM_W  = 64;                   // weighted sums

	// defaults for the top level parameters
	localparam int MAX_VERTICES_DEF  = 4096;
	localparam int COORD_WIDTH_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 8;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0]   OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0]   OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

	// status of an iterative unit toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// ===== rtl/pcs_ifs.sv =====
interface pcs_vtx_if;
	import pcs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic                      last_vertex;

	modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
	modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pcs_res_if;
	import pcs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] centroid_x;
	logic signed [OUT_W-1:0] centroid_y;
	logic                    degenerate;
	logic                    overflow;

	modport source (output valid, centroid_x, centroid_y, degenerate, overflow, input ready);
	modport sink   (input valid, centroid_x, centroid_y, degenerate, overflow, output ready);
endinterface

// ===== rtl/polygon_centroid_shoelace_core.sv =====
// Polygon centroid by the shoelace formula. Vertices arrive one per beat on vtx,
// the beat with last_vertex set closes the ring, and one beat on res then carries
// the centroid in Q.FRACTION_BITS, truncated toward zero and saturated to 24 bits.
// A ring of zero area gives the bounding-box center with degenerate set; more than
// MAX_VERTICES vertices gives overflow with zero fields. From one accepted vertex
// to the next, a vertex that adds an edge runs the six steps of the edge unit on
// the shared 17x33 multiplier (two cross products, then two weighted products);
// the first vertex of a ring adds no edge. A last vertex runs its own edge and the
// closing edge, then two restoring divisions (x, then y) on one compare-subtract
// unit, 25 quotient bits each, and then the emit. A zero-area ring skips the
// divisions; an overflowed ring's last vertex adds no edge and jumps to the emit.
// The next vertex is taken while a result still waits on res; only the emit of
// the following ring waits for res to free up.
module polygon_centroid_shoelace_core #(
	parameter int MAX_VERTICES  = pcs_pkg::MAX_VERTICES_DEF,
	parameter int COORD_WIDTH   = pcs_pkg::COORD_WIDTH_DEF,
	parameter int FRACTION_BITS = pcs_pkg::FRACTION_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	pcs_vtx_if.sink  vtx,
	pcs_res_if.source res
);
	import pcs_pkg::*;

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int SH    = COORD_W - COORD_WIDTH;    // sign extension from COORD_WIDTH
	localparam int BOX_W = OUT_W + 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WAIT_V = 3'd1;    // edge of the incoming vertex
	localparam logic [2:0] ST_WAIT_C = 3'd2;    // closing edge back to the first vertex
	localparam logic [2:0] ST_DIV_X  = 3'd3;
	localparam logic [2:0] ST_DIV_Y  = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0]                state_q;
	logic                      last_q;
	logic [CNT_W-1:0]          count_q;
	logic                      exceeded_q;
	logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;

	// staged result, then the output register
	logic signed [OUT_W-1:0]   stg_cx_q, stg_cy_q;
	logic                      stg_degen_q, stg_ovf_q;
	logic                      out_valid_q;
	logic signed [OUT_W-1:0]   out_cx_q, out_cy_q;
	logic                      out_degen_q, out_ovf_q;

	logic signed [COORD_W-1:0] x_shl, y_shl, x_in, y_in;
	logic                      accept, take_vtx, full;
	logic                      edge_start, poly_clear, emit_go;
	logic signed [COORD_W-1:0] e_x0, e_y0, e_x1, e_y1;
	unit_stat_t                edge_st, div_st;
	logic signed [AREA_W-1:0]  area;
	logic signed [WSUM_W-1:0]  wsum_x, wsum_y;
	logic                      div_start;
	logic signed [WSUM_W-1:0]  div_num;
	logic signed [OUT_W-1:0]   div_res;
	logic signed [BOX_W-1:0]   box_sx, box_sy, box_cx, box_cy;

	// keep the low COORD_WIDTH bits of each coordinate, sign extended
	assign x_shl = vtx.vertex_x <<< SH;
	assign y_shl = vtx.vertex_y <<< SH;
	assign x_in  = x_shl >>> SH;
	assign y_in  = y_shl >>> SH;

	assign vtx.ready = (state_q == ST_IDLE);
	assign accept    = vtx.valid && vtx.ready;
	assign full      = (count_q >= CNT_W'(MAX_VERTICES));
	assign take_vtx  = accept && !exceeded_q && !full;

	// vertex edge from the previous vertex, or the closing edge to the first one
	assign edge_start = (take_vtx && (count_q != '0))
		|| ((state_q == ST_WAIT_V) && !edge_st.busy && last_q && !exceeded_q);
	always_comb begin
		if (state_q == ST_WAIT_V) begin
			e_x1 = first_x_q;
			e_y1 = first_y_q;
		end else begin
			e_x1 = x_in;
			e_y1 = y_in;
		end
	end
	assign e_x0 = prev_x_q;
	assign e_y0 = prev_y_q;

	assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || res.ready);
	assign poly_clear = emit_go;

	pcs_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (edge_start),
		.clear  (poly_clear),
		.x0     (e_x0),
		.y0     (e_y0),
		.x1     (e_x1),
		.y1     (e_y1),
		.stat   (edge_st),
		.area   (area),
		.wsum_x (wsum_x),
		.wsum_y (wsum_y)
	);

	// x division after the closing edge, y division once the divider is back idle
	assign div_start = ((state_q == ST_WAIT_C) && !edge_st.busy && (area != '0))
		|| ((state_q == ST_DIV_Y) && !div_st.busy);
	assign div_num   = (state_q == ST_WAIT_C) ? wsum_x : wsum_y;

	pcs_div #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.area   (area),
		.stat   (div_st),
		.result (div_res)
	);

	// bounding-box center: floor((min + max) * 2^FRACTION_BITS / 2)
	assign box_sx = BOX_W'(min_x_q) + BOX_W'(max_x_q);
	assign box_sy = BOX_W'(min_y_q) + BOX_W'(max_y_q);
	assign box_cx = (box_sx <<< FRACTION_BITS) >>> 1;
	assign box_cy = (box_sy <<< FRACTION_BITS) >>> 1;

	// sequencer and polygon state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			last_q     <= 1'b0;
			count_q    <= '0;
			exceeded_q <= 1'b0;
			first_x_q  <= '0;
			first_y_q  <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			min_x_q    <= COORD_MAX;
			max_x_q    <= COORD_MIN;
			min_y_q    <= COORD_MAX;
			max_y_q    <= COORD_MIN;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q  <= vtx.last_vertex;
						state_q <= ST_WAIT_V;
						if (!exceeded_q && full) begin
							exceeded_q <= 1'b1;
						end else if (take_vtx) begin
							if (count_q == '0) begin
								first_x_q <= x_in;
								first_y_q <= y_in;
							end
							prev_x_q <= x_in;
							prev_y_q <= y_in;
							count_q  <= count_q + 1'b1;
							if (x_in < min_x_q) min_x_q <= x_in;
							if (x_in > max_x_q) max_x_q <= x_in;
							if (y_in < min_y_q) min_y_q <= y_in;
							if (y_in > max_y_q) max_y_q <= y_in;
						end
					end
				end
				ST_WAIT_V: begin
					if (!edge_st.busy) begin
						if (!last_q)         state_q <= ST_IDLE;
						else if (exceeded_q) state_q <= ST_EMIT;
						else                 state_q <= ST_WAIT_C;
					end
				end
				ST_WAIT_C: begin
					if (!edge_st.busy) begin
						state_q <= (area == '0) ? ST_EMIT : ST_DIV_X;
					end
				end
				ST_DIV_X: if (div_st.done) state_q <= ST_DIV_Y;
				ST_DIV_Y: if (div_st.done) state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_go) begin
						state_q    <= ST_IDLE;
						count_q    <= '0;
						exceeded_q <= 1'b0;
						first_x_q  <= '0;
						first_y_q  <= '0;
						prev_x_q   <= '0;
						prev_y_q   <= '0;
						min_x_q    <= COORD_MAX;
						max_x_q    <= COORD_MIN;
						min_y_q    <= COORD_MAX;
						max_y_q    <= COORD_MIN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result staging
	always_ff @(posedge clk) begin
		if ((state_q == ST_WAIT_V) && !edge_st.busy && last_q && exceeded_q) begin
			stg_cx_q    <= '0;
			stg_cy_q    <= '0;
			stg_degen_q <= 1'b0;
			stg_ovf_q   <= 1'b1;
		end
		if ((state_q == ST_WAIT_C) && !edge_st.busy) begin
			stg_cx_q    <= box_cx[OUT_W-1:0];
			stg_cy_q    <= box_cy[OUT_W-1:0];
			stg_degen_q <= (area == '0);
			stg_ovf_q   <= 1'b0;
		end
		if ((state_q == ST_DIV_X) && div_st.done) stg_cx_q <= div_res;
		if ((state_q == ST_DIV_Y) && div_st.done) stg_cy_q <= div_res;
	end

	// output register, parts the result side from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_cx_q    <= stg_cx_q;
			out_cy_q    <= stg_cy_q;
			out_degen_q <= stg_degen_q;
			out_ovf_q   <= stg_ovf_q;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.centroid_x = out_cx_q;
	assign res.centroid_y = out_cy_q;
	assign res.degenerate = out_degen_q;
	assign res.overflow   = out_ovf_q;

endmodule

// ===== rtl/pcs_edge.sv =====
module pcs_edge (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic                                     clear,
	input  logic signed [pcs_pkg::COORD_W-1:0]       x0,
	input  logic signed [pcs_pkg::COORD_W-1:0]       y0,
	input  logic signed [pcs_pkg::COORD_W-1:0]       x1,
	input  logic signed [pcs_pkg::COORD_W-1:0]       y1,
	output pcs_pkg::unit_stat_t                      stat,
	output logic signed [pcs_pkg::AREA_W-1:0]        area,
	output logic signed [pcs_pkg::WSUM_W-1:0]        wsum_x,
	output logic signed [pcs_pkg::WSUM_W-1:0]        wsum_y
);
	import pcs_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_P1   = 3'd1;
	localparam logic [2:0] S_P2   = 3'd2;
	localparam logic [2:0] S_C    = 3'd3;
	localparam logic [2:0] S_WX   = 3'd4;
	localparam logic [2:0] S_WY   = 3'd5;
	localparam logic [2:0] S_ACC  = 3'd6;

	logic [2:0]                step_q;
	logic signed [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [CROSS_W-1:0] c_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [AREA_W-1:0]  area_q;
	logic signed [WSUM_W-1:0]  wx_q, wy_q;

	logic signed [SUM2_W-1:0]  mul_a;
	logic signed [CROSS_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			S_P1: begin
				mul_a = SUM2_W'(x0_q);
				mul_b = CROSS_W'(y1_q);
			end
			S_P2: begin
				mul_a = SUM2_W'(x1_q);
				mul_b = CROSS_W'(y0_q);
			end
			S_WX: begin
				mul_a = SUM2_W'(x0_q) + SUM2_W'(x1_q);
				mul_b = c_q;
			end
			S_WY: begin
				mul_a = SUM2_W'(y0_q) + SUM2_W'(y1_q);
				mul_b = c_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (start) begin
			x0_q <= x0;
			y0_q <= y0;
			x1_q <= x1;
			y1_q <= y1;
		end
		prod_q <= mul_p;
		if (step_q == S_P2) begin
			c_q <= prod_q[CROSS_W-1:0];
		end else if (step_q == S_C) begin
			c_q <= c_q - prod_q[CROSS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
			area_q <= '0;
			wx_q   <= '0;
			wy_q   <= '0;
		end else begin
			unique case (step_q)
				S_IDLE: if (start) step_q <= S_P1;
				S_P1:   step_q <= S_P2;
				S_P2:   step_q <= S_C;
				S_C:    step_q <= S_WX;
				S_WX: begin
					area_q <= area_q + AREA_W'(c_q);
					step_q <= S_WY;
				end
				S_WY: begin
					wx_q   <= wx_q + WSUM_W'(prod_q);
					step_q <= S_ACC;
				end
				S_ACC: begin
					wy_q   <= wy_q + WSUM_W'(prod_q);
					step_q <= S_IDLE;
				end
				default: step_q <= S_IDLE;
			endcase
			if (clear) begin
				area_q <= '0;
				wx_q   <= '0;
				wy_q   <= '0;
			end
		end
	end

	assign stat.busy = (step_q != S_IDLE);
	assign stat.done = (step_q == S_ACC);
	assign area      = area_q;
	assign wsum_x    = wx_q;
	assign wsum_y    = wy_q;

endmodule

// ===== rtl/pcs_div.sv =====
module pcs_div #(
	parameter int FRACTION_BITS = pcs_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [pcs_pkg::WSUM_W-1:0]    num,
	input  logic signed [pcs_pkg::AREA_W-1:0]    area,
	output pcs_pkg::unit_stat_t                  stat,
	output logic signed [pcs_pkg::OUT_W-1:0]     result
);
	import pcs_pkg::*;

	localparam int DEN_W  = AREA_W + 2;          // 3 * |area|
	localparam int Q_W    = OUT_W + 1;           // top bit flags saturation
	localparam int REM_W  = DEN_W + Q_W - 1;
	localparam int ITER_W = $clog2(Q_W);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_PREP = 2'd1;
	localparam logic [1:0] D_RUN  = 2'd2;
	localparam logic [1:0] D_FIN  = 2'd3;

	logic [1:0]        st_q;
	logic [ITER_W-1:0] iter_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  dsh_q;
	logic [AREA_W-1:0] mag_q;
	logic [Q_W-1:0]    quo_q;
	logic              neg_q;

	logic [WSUM_W-1:0] num_mag;
	logic [AREA_W-1:0] area_mag;
	logic [DEN_W-1:0]  den3;
	logic [REM_W:0]    trial;
	logic [OUT_W-1:0]  qmag;
	logic              sat;

	assign num_mag  = num[WSUM_W-1] ? WSUM_W'(-num) : WSUM_W'(num);
	assign area_mag = area[AREA_W-1] ? AREA_W'(-area) : AREA_W'(area);
	assign den3     = DEN_W'(mag_q) + (DEN_W'(mag_q) << 1);
	assign trial    = {1'b0, rem_q} - {1'b0, dsh_q};

	always_ff @(posedge clk) begin
		unique case (st_q)
			D_IDLE: begin
				if (start) begin
					rem_q <= REM_W'(num_mag) << FRACTION_BITS;
					mag_q <= area_mag;
					neg_q <= num[WSUM_W-1] ^ area[AREA_W-1];
				end
			end
			D_PREP: begin
				dsh_q <= REM_W'(den3) << (Q_W - 1);
				quo_q <= '0;
			end
			D_RUN: begin
				if (!trial[REM_W]) begin
					rem_q <= trial[REM_W-1:0];
				end
				quo_q <= {quo_q[Q_W-2:0], ~trial[REM_W]};
				dsh_q <= dsh_q >> 1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			iter_q <= '0;
		end else begin
			unique case (st_q)
				D_IDLE: if (start) st_q <= D_PREP;
				D_PREP: begin
					iter_q <= '0;
					st_q   <= D_RUN;
				end
				D_RUN: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(Q_W - 1)) st_q <= D_FIN;
				end
				D_FIN:   st_q <= D_IDLE;
				default: st_q <= D_IDLE;
			endcase
		end
	end

	// saturate to the signed output range
	assign sat  = quo_q[Q_W-1];
	assign qmag = quo_q[Q_W-2:0];

	always_comb begin
		if (neg_q) begin
			if (sat || (qmag > OUT_W'(OUT_MIN))) result = OUT_MIN;
			else                                   result = -$signed(qmag);
		end else begin
			if (sat || qmag[OUT_W-1]) result = OUT_MAX;
			else                      result = $signed(qmag);
		end
	end

	assign stat.busy = (st_q != D_IDLE);
	assign stat.done = (st_q == D_FIN);

endmodule
